>>> rtl/lp12r_pkg.sv
// Shared types, constants and round functions for the 12-round lane permutation.
package lp12r_pkg;

  localparam int unsigned LaneW     = 64;
  localparam int unsigned LaneCount = 25;
  localparam int unsigned IdxW      = 5;
  localparam int unsigned RcTotal   = 12;
  localparam int unsigned RoundCountDefault = 12;
  localparam int unsigned ParRotA   = 26;
  localparam int unsigned ParRotB   = 27;
  localparam int unsigned MixRot    = 36;

  typedef logic [LaneW-1:0] lane_t;
  typedef lane_t [LaneCount-1:0] state_t;

  // Queue entry: one lane and whether it closes a block.
  typedef struct packed {
    lane_t lane;
    logic  last;
  } req_t;

  function automatic lane_t rot_r(input lane_t v, input int unsigned n);
    int unsigned m;
    m = n % 64;
    if (m == 0) return v;
    return (v >> m) | (v << (64 - m));
  endfunction

  function automatic lane_t round_key(input logic [3:0] r);
    lane_t k;
    case (r)
      4'd0: k = 64'h0001;
      4'd1: k = 64'h0003;
      4'd2: k = 64'h000A;
      4'd3: k = 64'h0088;
      4'd4: k = 64'h8081;
      4'd5: k = 64'h8002;
      4'd6: k = 64'h0009;
      4'd7: k = 64'h0083;
      4'd8: k = 64'h800A;
      4'd9: k = 64'h0089;
      4'd10: k = 64'h8083;
      4'd11: k = 64'h800B;
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic int unsigned lane_rot(input int unsigned i);
    int unsigned t [25];
    t = '{45, 33, 13, 1, 27, 40, 52, 19, 47, 9, 34, 5, 0, 2, 37,
          48, 30, 61, 8, 38, 6, 18, 49, 17, 43};
    return t[i];
  endfunction

  function automatic int unsigned lane_src(input int unsigned i);
    int unsigned t [25];
    t = '{4, 5, 11, 17, 23, 2, 8, 14, 15, 21, 0, 6, 12, 18, 24,
          3, 9, 10, 16, 22, 1, 7, 13, 19, 20};
    return t[i];
  endfunction

  function automatic int unsigned row_rot(input int unsigned y);
    int unsigned t [5];
    t = '{41, 50, 6, 10, 27};
    return t[y];
  endfunction

  function automatic state_t do_round(input state_t s_in, input logic [3:0] r);
    state_t s;
    state_t p;
    lane_t par [5];
    lane_t rpar [5];
    lane_t e [5];
    lane_t f [5];
    lane_t a0, a1, a2, a3, a4;
    s = s_in;
    s[0] = s[0] ^ round_key(r);
    for (int i = 0; i < 25; i++) s[i] = rot_r(s[i], lane_rot(i));
    for (int x = 0; x < 5; x++) begin
      par[x] = '0;
      rpar[x] = '0;
      for (int y = 0; y < 5; y++) begin
        par[x] = par[x] ^ s[x + 5 * y];
        rpar[x] = rpar[x] ^ rot_r(s[x + 5 * y], row_rot(y));
      end
    end
    for (int x = 0; x < 5; x++) begin
      e[x] = rot_r(par[x], ParRotA) ^ rot_r(par[(x + 4) % 5], ParRotB);
      f[x] = rpar[(x + 1) % 5] ^ rot_r(rpar[(x + 3) % 5], MixRot);
    end
    for (int x = 0; x < 5; x++)
      for (int y = 0; y < 5; y++)
        s[x + 5 * y] = s[x + 5 * y] ^ e[x] ^ rot_r(f[x], (row_rot(y) + ParRotA) % 64);
    for (int i = 0; i < 25; i++) p[i] = s[lane_src(i)];
    for (int x = 0; x < 5; x++) begin
      a0 = p[x]; a1 = p[x + 5]; a2 = p[x + 10]; a3 = p[x + 15]; a4 = p[x + 20];
      p[x]      = a3 ^ (~a1 & a2 & ~a4);
      p[x + 5]  = a4 ^ (~a2 & a3 & ~a0);
      p[x + 10] = a0 ^ (~a3 & a4 & ~a1);
      p[x + 15] = a1 ^ (~a4 & a0 & ~a2);
      p[x + 20] = a2 ^ (~a0 & a1 & ~a3);
    end
    return p;
  endfunction

endpackage

>>> rtl/lp12r_front.sv
// Input stage: accept lanes, count the fill and tag the closing lane.
module lp12r_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic [63:0]           lane_in_i,
  output logic                  q_valid_o,
  input  logic                  q_ready_i,
  output lp12r_pkg::req_t       q_req_o
);

  logic [4:0] fill_q, fill_d;
  logic       acc;

  assign ready_o   = q_ready_i;
  assign q_valid_o = valid_i;
  assign acc       = valid_i & q_ready_i;
  assign q_req_o.lane = lane_in_i;
  assign q_req_o.last = (fill_q == 5'(lp12r_pkg::LaneCount - 1));

  always_comb begin
    fill_d = fill_q;
    if (acc) fill_d = q_req_o.last ? '0 : fill_q + 5'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

endmodule

>>> rtl/lp12r_queue.sv
// Two-entry request queue between the input stage and the round engine.
module lp12r_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  lp12r_pkg::req_t in_req_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output lp12r_pkg::req_t out_req_o
);

  lp12r_pkg::req_t mem_q [2];
  logic            wp_q, rp_q;
  logic [1:0]      cnt_q;
  logic            push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_req_o   = mem_q[rp_q];
  assign push = in_valid_i & in_ready_o;
  assign pop  = out_valid_o & out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_req_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> rtl/lp12r_back.sv
// Round engine: store lanes, run the rounds one per cycle, emit the lanes.
module lp12r_back #(
  parameter int unsigned ROUND_COUNT = lp12r_pkg::RoundCountDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  output logic            q_ready_o,
  input  lp12r_pkg::req_t q_req_i,
  output logic            valid_o,
  input  logic            ready_i,
  output logic [63:0]     lane_out_o,
  output logic [4:0]      lane_index_o,
  output logic            last_lane_o
);

  localparam logic [1:0] StLoad = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;
  localparam logic [3:0] LastRound = 4'(ROUND_COUNT - 1);

  logic [1:0]           st_q, st_d;
  logic [3:0]           rnd_q, rnd_d;
  logic [4:0]           cnt_q, cnt_d;
  lp12r_pkg::state_t    s_q, s_d;
  logic                 take, give;

  assign q_ready_o    = (st_q == StLoad);
  assign take         = q_valid_i & q_ready_o;
  assign valid_o      = (st_q == StEmit);
  assign give         = valid_o & ready_i;
  assign lane_out_o   = s_q[0];
  assign lane_index_o = cnt_q;
  assign last_lane_o  = (cnt_q == 5'(lp12r_pkg::LaneCount - 1));

  always_comb begin
    st_d  = st_q;
    rnd_d = rnd_q;
    cnt_d = cnt_q;
    s_d   = s_q;
    unique case (st_q)
      StLoad: begin
        if (take) begin
          s_d = {q_req_i.lane, s_q[24:1]};
          if (q_req_i.last) begin
            st_d  = StRun;
            rnd_d = '0;
          end
        end
      end
      StRun: begin
        s_d   = lp12r_pkg::do_round(s_q, rnd_q);
        rnd_d = rnd_q + 4'd1;
        if (rnd_q == LastRound) begin
          st_d  = StEmit;
          cnt_d = '0;
        end
      end
      StEmit: begin
        if (give) begin
          s_d   = {s_q[0], s_q[24:1]};
          cnt_d = cnt_q + 5'd1;
          if (last_lane_o) st_d = StLoad;
        end
      end
      default: st_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i) begin
    s_q <= s_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= StLoad;
      rnd_q <= '0;
      cnt_q <= '0;
    end else begin
      st_q  <= st_d;
      rnd_q <= rnd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> rtl/lane_permutation_12_round.sv
// Top level of the 12-round lane permutation.
// The last lane request passes through the queue into the lane store; after the rounds the first result is offered.
// A block is 25 lane loads, ROUND_COUNT rounds and 25 lane outputs; the engine takes no new
// block until its last lane is emitted (single round unit, one-lane store port).
// Reset clears fill count, queue and engine state; the lane store is not cleared.
module lane_permutation_12_round #(
  parameter int unsigned ROUND_COUNT = lp12r_pkg::RoundCountDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [63:0] lane_in_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [63:0] lane_out_o,
  output logic [4:0]  lane_index_o,
  output logic        last_lane_o
);

  logic            f_valid, f_ready, b_valid, b_ready;
  lp12r_pkg::req_t f_req, b_req;

  lp12r_front u_front (
    .clk_i, .rst_ni, .valid_i, .ready_o, .lane_in_i,
    .q_valid_o(f_valid), .q_ready_i(f_ready), .q_req_o(f_req)
  );

  lp12r_queue u_queue (
    .clk_i, .rst_ni,
    .in_valid_i(f_valid), .in_ready_o(f_ready), .in_req_i(f_req),
    .out_valid_o(b_valid), .out_ready_i(b_ready), .out_req_o(b_req)
  );

  lp12r_back #(.ROUND_COUNT(ROUND_COUNT)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(b_valid), .q_ready_o(b_ready), .q_req_i(b_req),
    .valid_o, .ready_i, .lane_out_o, .lane_index_o, .last_lane_o
  );

endmodule
